// ===== hw/rtl/pscl_pkg.sv =====
package pscl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_BITS     = 32;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS      = 8;
    localparam int CTR_BITS      = 32;

    localparam logic [CNT_BITS-1:0] COUNT_MAX     = 8'd255;
    localparam logic [CNT_BITS-1:0] DEFAULT_LIMIT = 8'd6;

    typedef enum logic [1:0] {
        MODE_ATTEMPT    = 2'd0,
        MODE_HANDSHAKE  = 2'd1,
        MODE_DISCONNECT = 2'd2,
        MODE_UNUSED     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVER    = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_COMMIT
    } state_t;

    // Lookup token that walks down the row of cells.
    typedef struct packed {
        logic                    active;
        logic [ADDR_BITS-1:0]    addr;
        logic                    hit;
        logic [IDX_BITS-1:0]     hit_idx;
        logic [CNT_BITS-1:0]     hit_count;
        logic                    free;
        logic [IDX_BITS-1:0]     free_idx;
    } token_t;

    // Entry update broadcast to all cells.
    typedef struct packed {
        logic                    we;
        logic [IDX_BITS-1:0]     idx;
        logic [ADDR_BITS-1:0]    addr;
        logic [CNT_BITS-1:0]     count;
        logic                    valid;
    } wr_t;

endpackage

// ===== hw/rtl/pscl_cell.sv =====
module pscl_cell import pscl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [IDX_BITS-1:0] cell_idx,
    input  token_t              tok_i,
    input  wr_t                 wr_i,
    output token_t              tok_o
);

    logic                 valid_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    token_t               tok_reg;
    token_t               tok_next;
    logic                 wr_hit;

    // Fold this entry into the passing token: first match and lowest free slot win.
    always_comb begin
        tok_next = tok_i;
        if (valid_reg && (addr_reg == tok_i.addr) && !tok_i.hit) begin
            tok_next.hit       = 1'b1;
            tok_next.hit_idx   = cell_idx;
            tok_next.hit_count = count_reg;
        end
        if (!valid_reg && !tok_i.free) begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = cell_idx;
        end
    end

    assign wr_hit = wr_i.we && (wr_i.idx == cell_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            tok_reg <= tok_next;
            if (wr_hit) begin
                valid_reg <= wr_i.valid;
                count_reg <= wr_i.count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            addr_reg <= wr_i.addr;
        end
    end

    assign tok_o = tok_reg;

endmodule

// ===== hw/rtl/per_source_connection_limiter_core.sv =====
// Attempts and disconnects launch a lookup token that walks the cell row one cell per cycle;
// handshakes and the unused mode skip the lookup and go straight to commit.
// One item at a time: s_ready is low from input accept until the item commits.
// A stalled result holds the commit; the result register lets the next item start meanwhile.
// Reset (aresetn, synchronous, active low): all entries free, counters zero, limit 6.
module per_source_connection_limiter_core import pscl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,

    // Input items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [31:0]         s_source_addr,
    input  logic                s_was_completed,

    // Result items
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_accepted,
    output logic [1:0]          m_status,
    output logic [31:0]         m_total_seen,
    output logic [31:0]         m_total_completed,
    output logic [31:0]         m_active_now,
    output logic [31:0]         m_checking_now,

    // Limit register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_max_conns_per_source
);

    state_t               state_reg, state_next;

    // Item held for the duration of its lookup
    mode_t                mode_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 done_reg;
    logic                 launch_reg, launch_next;

    token_t               res_reg;
    token_t               chain [TABLE_ENTRIES+1];
    wr_t                  wr;

    logic [CNT_BITS-1:0]  limit_reg;

    logic [CTR_BITS-1:0]  seen_reg, seen_next;
    logic [CTR_BITS-1:0]  completed_reg, completed_next;
    logic [CTR_BITS-1:0]  active_reg, active_next;
    logic [CTR_BITS-1:0]  checking_reg, checking_next;

    logic                 m_valid_reg;
    logic                 m_accepted_reg, m_accepted_next;
    status_t              m_status_reg, m_status_next;

    logic                 s_fire;
    logic                 needs_sweep;
    logic                 out_free;
    logic                 commit;
    logic [CNT_BITS-1:0]  cnt_base;
    logic [CNT_BITS-1:0]  cnt_inc;
    logic [CNT_BITS-1:0]  cnt_dec;

    assign s_ready     = (state_reg == S_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign needs_sweep = (mode_t'(s_mode) == MODE_ATTEMPT) ||
                         (mode_t'(s_mode) == MODE_DISCONNECT);
    assign out_free    = !m_valid_reg || m_ready;
    assign cfg_ready   = 1'b1;

    // Inject the lookup token at the head of the row for one cycle.
    always_comb begin
        chain[0]           = '0;
        chain[0].active    = launch_reg;
        chain[0].addr      = addr_reg;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        pscl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_BITS'(i)),
            .tok_i    (chain[i]),
            .wr_i     (wr),
            .tok_o    (chain[i+1])
        );
    end

    // Control: wait for the token to leave the last cell, then commit once
    // the result register is free.
    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        commit      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    launch_next = needs_sweep;
                    state_next  = needs_sweep ? S_SWEEP : S_COMMIT;
                end
            end
            S_SWEEP: begin
                if (chain[TABLE_ENTRIES].active) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    // Capture the item and the finished lookup.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg <= mode_t'(s_mode);
            addr_reg <= ADDR_BITS'(s_source_addr);
            done_reg <= s_was_completed;
        end
        if (chain[TABLE_ENTRIES].active) begin
            res_reg <= chain[TABLE_ENTRIES];
        end
    end

    // Entry count arithmetic; a new source starts from zero.
    assign cnt_base = res_reg.hit ? res_reg.hit_count : '0;
    assign cnt_inc  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
    assign cnt_dec  = (res_reg.hit_count == '0) ? res_reg.hit_count
                                                : res_reg.hit_count - 1'b1;

    // Commit: table update, counter update and result, all in the same cycle.
    always_comb begin
        wr              = '0;
        wr.addr         = addr_reg;
        wr.idx          = res_reg.hit ? res_reg.hit_idx : res_reg.free_idx;
        seen_next       = seen_reg;
        completed_next  = completed_reg;
        active_next     = active_reg;
        checking_next   = checking_reg;
        m_accepted_next = 1'b0;
        m_status_next   = ST_OK;
        unique case (mode_reg)
            MODE_ATTEMPT: begin
                seen_next     = seen_reg + 1'b1;
                active_next   = active_reg + 1'b1;
                checking_next = checking_reg + 1'b1;
                if (res_reg.hit || res_reg.free) begin
                    wr.we    = commit;
                    wr.count = cnt_inc;
                    wr.valid = 1'b1;
                    if (cnt_inc > limit_reg) begin
                        m_status_next = ST_OVER;
                    end else begin
                        m_accepted_next = 1'b1;
                    end
                end else begin
                    m_status_next = ST_FULL;
                end
            end
            MODE_HANDSHAKE: begin
                completed_next = completed_reg + 1'b1;
                checking_next  = checking_reg - 1'b1;
            end
            MODE_DISCONNECT: begin
                active_next = active_reg - 1'b1;
                if (!done_reg) begin
                    checking_next = checking_reg - 1'b1;
                end
                if (res_reg.hit) begin
                    wr.we    = commit;
                    wr.count = cnt_dec;
                    wr.valid = (cnt_dec != '0);
                end else begin
                    m_status_next = ST_UNKNOWN;
                end
            end
            MODE_UNUSED: begin
                // No state change; report current counters.
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            completed_reg <= '0;
            active_reg    <= '0;
            checking_reg  <= '0;
            limit_reg     <= DEFAULT_LIMIT;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                // Clamp a zero limit to one.
                limit_reg <= (cfg_max_conns_per_source == '0) ? 8'd1
                                                              : cfg_max_conns_per_source;
            end
            if (commit) begin
                seen_reg      <= seen_next;
                completed_reg <= completed_next;
                active_reg    <= active_next;
                checking_reg  <= checking_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    // Result payload; the counter registers update at commit, so they reflect this item.
    always_ff @(posedge aclk) begin
        if (commit) begin
            m_accepted_reg <= m_accepted_next;
            m_status_reg   <= m_status_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = m_accepted_reg;
    assign m_status          = m_status_reg;
    assign m_total_seen      = seen_reg;
    assign m_total_completed = completed_reg;
    assign m_active_now      = active_reg;
    assign m_checking_now    = checking_reg;

endmodule

// ===== hw/rtl/pscl_checker.sv =====
module pscl_checker import pscl_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_accepted,
    input logic [1:0]  m_status,
    input logic [31:0] m_total_seen,
    input logic [31:0] m_active_now
);

    // A stalled result holds its counters.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_seen) && $stable(m_active_now))
        else $error("stalled result changed");

    // An accepted attempt always reports ok.
    a_acc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_status == ST_OK)
        else $error("accepted with non-ok status");

    // One item in flight: input closes right after an accept.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

endmodule

bind per_source_connection_limiter_core pscl_checker u_pscl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_accepted   (m_accepted),
    .m_status     (m_status),
    .m_total_seen (m_total_seen),
    .m_active_now (m_active_now)
);
